@@ design/daq_word_pair_unpacker_assert.svh @@
// ----------------------------------------------------------------------------
// daq word pair unpacker assertion macros
// shared assertion forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef DAQ_WORD_PAIR_UNPACKER_ASSERT_SVH
`define DAQ_WORD_PAIR_UNPACKER_ASSERT_SVH

// condition implies consequence in the same cycle
`define DAQWP_ASSERT_NOW(label, cond_a, cond_c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_c)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define DAQWP_ASSERT_NEXT(label, cond_a, cond_c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_c)) \
        else $error(msg);

`endif

@@ design/daqwp_pkg.sv @@
// ----------------------------------------------------------------------------
// daqwp_pkg
// types, codes and helpers shared by the word pair unpacker modules
// ----------------------------------------------------------------------------
package daqwp_pkg;

    localparam int WORD_W     = 32;
    localparam int MOD_W      = 6;
    localparam int CHAN_W     = 6;
    localparam int VALUE_W    = 16;
    localparam int CODE_W     = 4;
    localparam int FIELD_W    = 20;
    localparam int TS_LOW_W   = 28;
    localparam int TS_HIGH_W  = 20;
    localparam int TS_FULL_W  = 48;
    localparam int PIECE_W    = 16;
    localparam int SCALER_W   = 48;
    localparam int ENABLE_W   = 32;
    localparam int IN_TDATA_W = 64;
    localparam int OUT_USED_W = 179;
    localparam int OUT_TDATA_W = 184;

    typedef enum logic [1:0] {
        DT_WAVE  = 2'd0,
        DT_TRACE = 2'd1,
        DT_INFO  = 2'd2,
        DT_ADC   = 2'd3
    } word_kind_t;

    // information word codes
    localparam logic [CODE_W-1:0] INFO_PAUSE  = 4'd2;
    localparam logic [CODE_W-1:0] INFO_RESUME = 4'd3;
    localparam logic [CODE_W-1:0] INFO_SYNC   = 4'd4;
    localparam logic [CODE_W-1:0] INFO_CORR   = 4'd8;

    // correlation scaler piece index
    localparam logic [3:0] PIECE_LOW  = 4'd0;
    localparam logic [3:0] PIECE_MID  = 4'd1;
    localparam logic [3:0] PIECE_HIGH = 4'd2;

    typedef struct packed {
        logic [PIECE_W-1:0] mid;
        logic [PIECE_W-1:0] low;
    } scaler_entry_t;

    typedef struct packed {
        logic          en;
        scaler_entry_t entry;
    } store_wr_t;

    typedef struct packed {
        word_kind_t             kind;
        logic [MOD_W-1:0]       module_id;
        logic [CHAN_W-1:0]      channel_id;
        logic                   range_sel;
        logic [VALUE_W-1:0]     value16;
        logic [CODE_W-1:0]      info_op;
        logic [FIELD_W-1:0]     info_arg;
        logic [TS_LOW_W-1:0]    timestamp_low;
        logic [TS_FULL_W-1:0]   timestamp_full;
        logic [SCALER_W-1:0]    scaler;
        logic                   in_sync;
        logic                   forward;
    } result_t;

    // module numbers run from 1 to n_modules
    function automatic logic module_in_range(input logic [MOD_W-1:0] m,
                                             input int unsigned n_modules);
        logic ok;
        ok = (m != '0) && (32'(m) <= n_modules);
        return ok;
    endfunction

endpackage

@@ design/daqwp_scaler_store.sv @@
// ----------------------------------------------------------------------------
// daqwp_scaler_store
// per-module scaler piece memory with registered read, valid bits and a
// write-to-read bypass for back-to-back access to the same slot
// ----------------------------------------------------------------------------
module daqwp_scaler_store
    import daqwp_pkg::*;
#(
    parameter int N_MODULES = 32,
    parameter int SLOT_W    = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_slot,
    input  store_wr_t         wr,
    input  logic [SLOT_W-1:0] wr_slot,
    output scaler_entry_t     rd_entry
);

    scaler_entry_t mem [N_MODULES];
    scaler_entry_t q_reg;
    scaler_entry_t byp_reg;

    logic [N_MODULES-1:0] valid_reg;
    logic                 q_valid_reg;
    logic                 byp_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_slot] <= wr.entry;
        end
        if (rd_en)
        begin
            q_reg   <= mem[rd_slot];
            byp_reg <= wr.entry;
        end
    end

    // never-written entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr_slot] <= 1'b1;
            end
            if (rd_en)
            begin
                q_valid_reg <= valid_reg[rd_slot];
                byp_hit_reg <= wr.en && (wr_slot == rd_slot);
            end
        end
    end

    always_comb
    begin
        if (byp_hit_reg)
        begin
            rd_entry = byp_reg;
        end
        else if (q_valid_reg)
        begin
            rd_entry = q_reg;
        end
        else
        begin
            rd_entry = '0;
        end
    end

endmodule

@@ design/daqwp_decode.sv @@
// ----------------------------------------------------------------------------
// daqwp_decode
// field extraction per data type, timestamp and sync state, scaler update
// ----------------------------------------------------------------------------
module daqwp_decode
    import daqwp_pkg::*;
#(
    parameter int N_MODULES = 32,
    parameter int SLOT_W    = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                commit,
    input  logic [WORD_W-1:0]   first_word,
    input  logic [WORD_W-1:0]   second_word,
    input  logic [ENABLE_W-1:0] module_enable,
    input  scaler_entry_t       entry,
    output result_t             result,
    output store_wr_t           wr,
    output logic [SLOT_W-1:0]   wr_slot
);

    logic [TS_HIGH_W-1:0] ts_high_reg;
    logic [TS_HIGH_W-1:0] ts_high_next;
    logic                 sync_reg;
    logic                 sync_next;

    logic [MOD_W-1:0]   mod_hit;
    logic [MOD_W-1:0]   mod_hit_m1;
    logic [MOD_W-1:0]   mod_info;
    logic [MOD_W-1:0]   mod_info_m1;
    logic [FIELD_W-1:0] field;
    logic [CODE_W-1:0]  code;
    logic [3:0]         piece_idx;
    logic [PIECE_W-1:0] piece;
    logic [TS_LOW_W-1:0] ts_low;
    logic               hit_enabled;
    logic               fwd;

    assign mod_hit     = first_word[27:22];
    assign mod_hit_m1  = mod_hit - MOD_W'(1);
    assign mod_info    = first_word[29:24];
    assign mod_info_m1 = mod_info - MOD_W'(1);
    assign field       = first_word[19:0];
    assign code        = first_word[23:20];
    assign piece_idx   = field[19:16];
    assign piece       = field[15:0];
    assign ts_low      = second_word[27:0];
    assign wr_slot     = mod_info_m1[SLOT_W-1:0];

    // enable bits only cover modules 1 to 32
    assign hit_enabled = module_in_range(mod_hit, N_MODULES)
                      && (mod_hit <= MOD_W'(ENABLE_W))
                      && module_enable[mod_hit_m1[4:0]];

    always_comb
    begin
        result       = '0;
        wr           = '0;
        wr.entry     = entry;
        ts_high_next = ts_high_reg;
        sync_next    = sync_reg;
        fwd          = 1'b0;
        result.kind  = word_kind_t'(first_word[31:30]);

        case (word_kind_t'(first_word[31:30]))
            DT_ADC:
            begin
                result.module_id     = mod_hit;
                result.channel_id    = first_word[21:16];
                result.range_sel     = first_word[28];
                result.value16       = first_word[15:0];
                result.timestamp_low = ts_low;
                fwd                  = hit_enabled;
            end
            DT_INFO:
            begin
                result.module_id     = mod_info;
                result.info_op       = code;
                result.info_arg      = field;
                result.timestamp_low = ts_low;
                if (code == INFO_PAUSE)
                begin
                    ts_high_next = field;
                end
                else if (code inside {INFO_RESUME, INFO_SYNC})
                begin
                    ts_high_next = field;
                    sync_next    = 1'b1;
                end
                else if (code == INFO_CORR && module_in_range(mod_info, N_MODULES))
                begin
                    if (piece_idx == PIECE_LOW)
                    begin
                        wr.en        = 1'b1;
                        wr.entry.low = piece;
                    end
                    else if (piece_idx == PIECE_MID)
                    begin
                        wr.en        = 1'b1;
                        wr.entry.mid = piece;
                    end
                    else if (piece_idx == PIECE_HIGH)
                    begin
                        result.scaler = {piece, entry.mid, entry.low};
                        fwd           = 1'b1;
                    end
                end
            end
            DT_TRACE:
            begin
                result.module_id     = mod_hit;
                result.channel_id    = first_word[21:16];
                result.value16       = first_word[15:0];
                result.timestamp_low = ts_low;
            end
            default:
            begin
                result.value16 = {2'b00, first_word[29:16]};
            end
        endcase

        // full timestamp uses state as updated by this word
        if (sync_next)
        begin
            result.timestamp_full = {ts_high_next, result.timestamp_low};
        end
        result.in_sync = sync_next;
        result.forward = fwd && sync_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_high_reg <= '0;
            sync_reg    <= 1'b0;
        end
        else if (commit)
        begin
            ts_high_reg <= ts_high_next;
            sync_reg    <= sync_next;
        end
    end

endmodule

@@ design/daq_word_pair_unpacker.sv @@
// ----------------------------------------------------------------------------
// daq_word_pair_unpacker
// path: an accepted word pair passes the stage 1 register, then the output register, to m_tvalid
// throughput: one word pair per cycle while m_tready does not stall the output register
// reset: module_enable all ones, timestamp and sync cleared, scaler slots zero
// ----------------------------------------------------------------------------
`include "daq_word_pair_unpacker_assert.svh"

module daq_word_pair_unpacker
    import daqwp_pkg::*;
#(
    parameter int N_MODULES = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // first_word[31:0], second_word[63:32]
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // module_id[5:0], channel_id[11:6],
                                              // range_sel[12], value16[28:13],
                                              // info_op[32:29], info_arg[52:33],
                                              // timestamp_low[80:53],
                                              // timestamp_full[128:81],
                                              // scaler[176:129], in_sync[177],
                                              // forward[178], zero pad[183:179]
    output logic [1:0]             m_tuser,   // kind[1:0]
    // module enable register
    input  logic                   cfg_wr_en,
    input  logic [ENABLE_W-1:0]    cfg_wr_data
);

    localparam int SLOT_W = (N_MODULES > 1) ? $clog2(N_MODULES) : 1;

    // pipeline: stage 0 accepts and issues the scaler read, stage 1 decodes and
    // writes the slot back, then the output register holds the result word
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [WORD_W-1:0]    s1_w0_reg;
    logic [WORD_W-1:0]    s1_w1_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    result_t              out_reg;
    logic [ENABLE_W-1:0]  enable_reg;

    logic                 accept;
    logic                 s1_adv;
    logic [MOD_W-1:0]     in_mod;
    logic [MOD_W-1:0]     in_mod_m1;
    logic                 rd_en;
    scaler_entry_t        rd_entry;
    store_wr_t            wr_req;
    store_wr_t            wr_gated;
    logic [SLOT_W-1:0]    wr_slot;
    result_t              s1_result;

    // stage 1 moves on when the output register is free or being emptied
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // scaler slot of an info word: module in bits 29:24 of first_word
    assign in_mod    = s_tdata[29:24];
    assign in_mod_m1 = in_mod - MOD_W'(1);
    assign rd_en     = accept && module_in_range(in_mod, N_MODULES);

    // slot write only when the decoded word leaves stage 1
    always_comb
    begin
        wr_gated    = wr_req;
        wr_gated.en = wr_req.en && s1_adv;
    end

    daqwp_scaler_store #(
        .N_MODULES (N_MODULES),
        .SLOT_W    (SLOT_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_slot  (in_mod_m1[SLOT_W-1:0]),
        .wr       (wr_gated),
        .wr_slot  (wr_slot),
        .rd_entry (rd_entry)
    );

    daqwp_decode #(
        .N_MODULES (N_MODULES),
        .SLOT_W    (SLOT_W)
    ) u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .commit        (s1_adv),
        .first_word    (s1_w0_reg),
        .second_word   (s1_w1_reg),
        .module_enable (enable_reg),
        .entry         (rd_entry),
        .result        (s1_result),
        .wr            (wr_req),
        .wr_slot       (wr_slot)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            enable_reg    <= '1;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                enable_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_w0_reg <= s_tdata[31:0];
            s1_w1_reg <= s_tdata[63:32];
        end
        if (s1_adv)
        begin
            out_reg <= s1_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {
        (OUT_TDATA_W - OUT_USED_W)'(0),
        out_reg.forward,
        out_reg.in_sync,
        out_reg.scaler,
        out_reg.timestamp_full,
        out_reg.timestamp_low,
        out_reg.info_arg,
        out_reg.info_op,
        out_reg.value16,
        out_reg.range_sel,
        out_reg.channel_id,
        out_reg.module_id
    };

    // nothing is forwarded before the block is synchronized
    `DAQWP_ASSERT_NOW(a_fwd_sync, m_tvalid && out_reg.forward, out_reg.in_sync, "fwd unsynced")
    // sync flag is sticky from one result word to the next
    `DAQWP_ASSERT_NEXT(a_sticky, m_tvalid && out_reg.in_sync, out_reg.in_sync, "sync dropped")
    // an empty output register never blocks the input side
    `DAQWP_ASSERT_NOW(a_ready_empty, !out_valid_reg, s_tready, "stall with empty output")
    // an assembled scaler only comes from an information word
    `DAQWP_ASSERT_NOW(a_scl_info, m_tvalid && |out_reg.scaler, m_tuser == DT_INFO, "stray scaler")

endmodule
